FILE: design/rewt2_pkg.sv
// rewt2_pkg: shared types and constants of the robust ewma t2 alarm block
// no dependencies
`timescale 1ns / 1ps
package rewt2_pkg;

  localparam int          FRAC_BITS = 16;
  localparam logic [46:0] T2_MAX    = {47{1'b1}};
  localparam logic [16:0] LAM_ONE   = 17'd65536;

  typedef enum logic [1:0] {
    FN_SAMPLE = 2'd0,
    FN_THR    = 2'd1,
    FN_LOAD   = 2'd2,
    FN_EIG    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_WEIGHT = 3'd0,
    CFG_HUBER  = 3'd1,
    CFG_LIMIT  = 3'd2,
    CFG_WARMUP = 3'd3,
    CFG_MONMAX = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic               vld;
    logic [5:0]         vidx;
    logic signed [31:0] y;
  } tok_t;

  typedef struct packed {
    logic        en;
    logic [5:0]  comp;
    logic [5:0]  vidx;
    logic [31:0] data;
  } ldw_t;

endpackage

FILE: design/rewt2_ram.sv
// rewt2_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module rewt2_ram #(
  parameter int W = 32,
  parameter int D = 8
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                   wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                   rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/rewt2_cell.sv
// rewt2_cell: one principal component cell, holds its loading column and accumulator
// depends on rewt2_pkg and rewt2_ram
`timescale 1ns / 1ps
module rewt2_cell
  import rewt2_pkg::*;
#(
  parameter int NUM_VARS = 8,
  parameter int CELL_ID  = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tok_t               tok_i,
  output tok_t               tok_o,
  input  ldw_t               ldw_i,
  input  logic               shift_i,
  input  logic signed [63:0] acc_i,
  output logic signed [63:0] acc_o
);

  localparam int AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam logic [5:0] MY_ID = 6'(CELL_ID);

  logic [31:0]        ld_rd;
  logic signed [31:0] ld_s;
  tok_t               tok_r;
  logic               pv_r;
  logic signed [63:0] p_r;
  logic signed [63:0] prod;
  logic signed [63:0] acc_r;
  logic signed [63:0] acc_nxt;
  logic signed [64:0] sum;

  rewt2_ram #(.W(32), .D(NUM_VARS)) u_ld (
    .clk   (clk),
    .we    (ldw_i.en && (ldw_i.comp == MY_ID)),
    .waddr (ldw_i.vidx[AW-1:0]),
    .wdata (ldw_i.data),
    .raddr (tok_i.vidx[AW-1:0]),
    .rdata (ld_rd)
  );

  assign ld_s = $signed(ld_rd);
  assign prod = tok_r.y * ld_s;
  assign sum  = {acc_r[63], acc_r} + {p_r[63], p_r};

  always_comb begin
    if (sum[64] != sum[63]) begin
      acc_nxt = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_nxt = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      tok_r <= tok_i;
      pv_r  <= tok_r.vld;
      if (shift_i) begin
        acc_r <= acc_i;
      end else if (pv_r) begin
        acc_r <= acc_nxt;
      end
    end
    p_r <= prod;
  end

  assign tok_o = tok_r;
  assign acc_o = acc_r;

endmodule

FILE: design/rewt2_t2.sv
// rewt2_t2: drains the cell accumulators and forms the saturating t2 sum
// depends on rewt2_pkg and rewt2_ram; serial square and serial divide
`timescale 1ns / 1ps
module rewt2_t2
  import rewt2_pkg::*;
#(
  parameter int NUM_COMPONENTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic signed [63:0] acc_i,
  output logic               shift_o,
  input  logic               eig_we_i,
  input  logic [5:0]         eig_waddr_i,
  input  logic [31:0]        eig_wdata_i,
  output logic               done_o,
  output logic [46:0]        t2_o
);

  localparam int CW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_EIG, S_MUL, S_DIV, S_ADD} st_t;

  st_t         state_r;
  logic [CW-1:0] cnt_r;
  logic [47:0] s_r;
  logic [95:0] mcand_r;
  logic [47:0] mplier_r;
  logic [95:0] prod_r;
  logic [95:0] prod_nxt;
  logic [6:0]  bit_r;
  logic [31:0] rem_r;
  logic [95:0] quo_r;
  logic [95:0] quo_nxt;
  logic [32:0] rem2;
  logic        qbit;
  logic [46:0] term_r;
  logic [46:0] sum_r;
  logic [47:0] sum_add;
  logic        done_r;
  logic [31:0] eig_rd;
  logic [63:0] mag;
  logic [63:0] rnd;

  rewt2_ram #(.W(32), .D(NUM_COMPONENTS)) u_eig (
    .clk   (clk),
    .we    (eig_we_i),
    .waddr (eig_waddr_i[CW-1:0]),
    .wdata (eig_wdata_i),
    .raddr (cnt_r),
    .rdata (eig_rd)
  );

  assign mag      = acc_i[63] ? 64'(-acc_i) : 64'(acc_i);
  assign rnd      = (mag + 64'd32768) >> FRAC_BITS;
  assign prod_nxt = mplier_r[0] ? (prod_r + mcand_r) : prod_r;
  assign rem2     = {rem_r, quo_r[95]};
  assign qbit     = (rem2 >= {1'b0, eig_rd});
  assign quo_nxt  = {quo_r[94:0], qbit};
  assign sum_add  = {1'b0, sum_r} + {1'b0, term_r};
  assign shift_o  = (state_r == S_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start_i) begin
            cnt_r   <= CW'(NUM_COMPONENTS - 1);
            sum_r   <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          s_r     <= rnd[47:0];
          state_r <= S_EIG;
        end
        S_EIG: begin
          if ($signed(eig_rd) <= 0) begin
            term_r  <= T2_MAX;
            state_r <= S_ADD;
          end else begin
            mcand_r  <= {48'd0, s_r};
            mplier_r <= s_r;
            prod_r   <= '0;
            bit_r    <= '0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r   <= prod_nxt;
          mcand_r  <= {mcand_r[94:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[47:1]};
          bit_r    <= bit_r + 7'd1;
          if (bit_r == 7'd47) begin
            quo_r   <= prod_nxt;
            rem_r   <= '0;
            bit_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= qbit ? 32'(rem2 - {1'b0, eig_rd}) : rem2[31:0];
          quo_r <= quo_nxt;
          bit_r <= bit_r + 7'd1;
          if (bit_r == 7'd95) begin
            term_r  <= (quo_nxt[95:47] != '0) ? T2_MAX : quo_nxt[46:0];
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          sum_r <= sum_add[47] ? T2_MAX : sum_add[46:0];
          if (cnt_r == '0) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_r;
  assign t2_o   = sum_r;

endmodule

FILE: design/robust_ewma_t2_alarm.sv
// robust_ewma_t2_alarm: top level, robust ewma update, cell chain and alarm logic
// depends on rewt2_pkg, rewt2_ram, rewt2_cell and rewt2_t2
`timescale 1ns / 1ps
// A sample element's updated entry travels the row of component cells one cell
// a cycle, and in bisquare mode the score runs a 48-step serial divider. The
// element that closes a sample adds the T2 drain: each accumulator is shifted
// out of the cell row, squared by a 48-step shift-add unit and divided by its
// eigenvalue in a 96-step serial divider. Only one item is in work at a time;
// a finished result waits in the output register while further requests are
// taken.
module robust_ewma_t2_alarm
  import rewt2_pkg::*;
#(
  parameter int NUM_VARS       = 8,
  parameter int NUM_COMPONENTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [2:0]         in_var_index,
  input  logic [2:0]         in_comp_index,
  input  logic signed [31:0] in_value,
  input  logic               in_last_var,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [46:0]        out_t2_value,
  output logic               out_in_warmup,
  output logic               out_alarm,
  output logic [15:0]        out_run_length,
  output logic               out_no_signal,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [46:0]        cfg_data
);

  localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int WAIT_N = NUM_COMPONENTS + 4;
  localparam int WW = $clog2(WAIT_N + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_HMUL, S_DIV, S_Q, S_D2, S_F, S_BMUL, S_UPD, S_WAIT, S_T2, S_FIN
  } st_t;

  st_t                state_r;
  logic [16:0]        sw_r;
  logic               huber_r;
  logic [46:0]        limit_r;
  logic [15:0]        warm_r;
  logic [15:0]        mmax_r;
  logic [16:0]        lam;
  logic [16:0]        oml;

  logic               acc_in;
  logic               vok_in;
  logic               cok_in;
  logic [5:0]         v6;
  logic [VW-1:0]      vaddr;
  logic [VW-1:0]      v_r;
  logic [5:0]         v6_r;
  logic signed [31:0] x_r;
  logic               last_r;
  logic [NUM_VARS-1:0] ev_r;
  logic [31:0]        thr_rd;
  logic [31:0]        ew_rd;
  logic signed [31:0] y_cur;
  logic signed [31:0] y_r;
  logic signed [31:0] k_r;
  logic signed [32:0] e_cur;
  logic [32:0]        e_mag_cur;
  logic signed [32:0] e_r;
  logic               bis_cur;
  logic               lt_r;
  logic               gt_r;
  logic               bis_r;
  logic               zero_r;

  logic [47:0]        dvd_r;
  logic [31:0]        drem_r;
  logic [32:0]        drem2;
  logic               dq;
  logic [5:0]         dcnt_r;
  logic [16:0]        q_r;
  logic [16:0]        d2_r;
  logic [16:0]        f_r;
  logic [16:0]        dd;
  logic [33:0]        uu;
  logic [33:0]        ddsq;
  logic [33:0]        od;
  logic signed [34:0] rm_r;
  logic signed [36:0] phi;
  logic signed [36:0] ny_w;
  logic signed [31:0] ny;

  tok_t               tok_r;
  ldw_t               ldw;
  logic [WW-1:0]      wcnt_r;
  logic               start_r;
  logic               t2_done;
  logic [46:0]        t2_w;
  logic [46:0]        t2_r;
  logic               shift;
  logic [16:0]        scnt_r;
  logic               fin_r;

  logic               ov_r;
  logic [46:0]        o_t2_r;
  logic               o_warm_r;
  logic               o_alarm_r;
  logic [15:0]        o_run_r;
  logic               o_nosig_r;

  logic               warm_w;
  logic [17:0]        run_w;
  logic [15:0]        mmax_w;
  logic               alarm_w;
  logic               nosig_w;

  tok_t               tok_c [NUM_COMPONENTS+1];
  logic signed [63:0] acc_c [NUM_COMPONENTS+1];

  function automatic logic signed [34:0] rmul(input logic signed [32:0] v,
                                              input logic [16:0] m);
    logic [32:0] mg;
    logic [49:0] p;
    logic [34:0] r;
    mg = v[32] ? 33'(-v) : 33'(v);
    p  = 50'(mg) * 50'(m) + 50'd32768;
    r  = 35'(p >> 16);
    return v[32] ? -$signed(r) : $signed(r);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign acc_in    = in_valid && in_ready;
  assign v6        = {3'd0, in_var_index};
  assign vaddr     = v6[VW-1:0];
  assign vok_in    = (int'(in_var_index) < NUM_VARS);
  assign cok_in    = (int'(in_comp_index) < NUM_COMPONENTS);
  assign lam       = (sw_r > LAM_ONE) ? LAM_ONE : sw_r;
  assign oml       = LAM_ONE - lam;

  rewt2_ram #(.W(32), .D(NUM_VARS)) u_thr (
    .clk   (clk),
    .we    (acc_in && (in_func == FN_THR) && vok_in),
    .waddr (vaddr),
    .wdata (in_value),
    .raddr (vaddr),
    .rdata (thr_rd)
  );

  rewt2_ram #(.W(32), .D(NUM_VARS)) u_ewma (
    .clk   (clk),
    .we    (state_r == S_UPD),
    .waddr (v_r),
    .wdata (ny),
    .raddr (vaddr),
    .rdata (ew_rd)
  );

  assign y_cur     = ev_r[v_r] ? $signed(ew_rd) : 32'sd0;
  assign e_cur     = 33'(x_r) - 33'(y_cur);
  assign e_mag_cur = e_cur[32] ? 33'(-e_cur) : 33'(e_cur);
  assign bis_cur   = ($signed(thr_rd) > 0) && (e_mag_cur <= {1'b0, thr_rd});

  assign drem2 = {drem_r, dvd_r[47]};
  assign dq    = (drem2 >= {1'b0, k_r});
  assign uu    = 34'(dvd_r[16:0]) * 34'(dvd_r[16:0]);
  assign dd    = LAM_ONE - q_r;
  assign ddsq  = 34'(dd) * 34'(dd);
  assign od    = 34'(oml) * 34'(d2_r);

  always_comb begin
    if (zero_r) begin
      phi = '0;
    end else if (huber_r) begin
      if (lt_r) begin
        phi = 37'(e_r) + 37'(rm_r);
      end else if (gt_r) begin
        phi = 37'(e_r) - 37'(rm_r);
      end else begin
        phi = 37'(rm_r);
      end
    end else begin
      phi = bis_r ? 37'(rm_r) : 37'(e_r);
    end
    ny_w = 37'(y_r) + phi;
    if (ny_w > 37'sd2147483647) begin
      ny = 32'sh7fffffff;
    end else if (ny_w < -37'sd2147483648) begin
      ny = 32'sh80000000;
    end else begin
      ny = ny_w[31:0];
    end
  end

  assign ldw.en   = acc_in && (in_func == FN_LOAD) && vok_in && cok_in;
  assign ldw.comp = {3'd0, in_comp_index};
  assign ldw.vidx = v6;
  assign ldw.data = in_value;

  assign tok_c[0] = tok_r;
  assign acc_c[0] = '0;

  for (genvar g = 0; g < NUM_COMPONENTS; g++) begin : g_cell
    rewt2_cell #(.NUM_VARS(NUM_VARS), .CELL_ID(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok_c[g]),
      .tok_o   (tok_c[g+1]),
      .ldw_i   (ldw),
      .shift_i (shift),
      .acc_i   (acc_c[g]),
      .acc_o   (acc_c[g+1])
    );
  end

  rewt2_t2 #(.NUM_COMPONENTS(NUM_COMPONENTS)) u_t2 (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start_r),
    .acc_i       (acc_c[NUM_COMPONENTS]),
    .shift_o     (shift),
    .eig_we_i    (acc_in && (in_func == FN_EIG) && cok_in),
    .eig_waddr_i ({3'd0, in_comp_index}),
    .eig_wdata_i (in_value),
    .done_o      (t2_done),
    .t2_o        (t2_w)
  );

  assign warm_w  = (scnt_r < {1'b0, warm_r});
  assign run_w   = {1'b0, scnt_r} - {2'd0, warm_r} + 18'd1;
  assign mmax_w  = (mmax_r == '0) ? 16'd1 : mmax_r;
  assign alarm_w = !warm_w && (t2_r > limit_r);
  assign nosig_w = !warm_w && !alarm_w && (run_w >= {2'd0, mmax_w});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sw_r    <= 17'd13107;
      huber_r <= 1'b1;
      limit_r <= T2_MAX;
      warm_r  <= '0;
      mmax_r  <= 16'hffff;
      ev_r    <= '0;
      tok_r   <= '0;
      start_r <= 1'b0;
      scnt_r  <= '0;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      tok_r.vld <= 1'b0;
      start_r   <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WEIGHT: sw_r    <= cfg_data[16:0];
          CFG_HUBER:  huber_r <= cfg_data[0];
          CFG_LIMIT:  limit_r <= cfg_data;
          CFG_WARMUP: warm_r  <= cfg_data[15:0];
          CFG_MONMAX: mmax_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc_in && (in_func == FN_SAMPLE) && !fin_r) begin
            v_r    <= vaddr;
            v6_r   <= v6;
            x_r    <= in_value;
            last_r <= in_last_var;
            wcnt_r <= '0;
            state_r <= vok_in ? S_ERR : S_WAIT;
          end
        end
        S_ERR: begin
          y_r    <= y_cur;
          k_r    <= $signed(thr_rd);
          e_r    <= e_cur;
          zero_r <= (e_cur == '0);
          lt_r   <= (34'(e_cur) < -34'($signed(thr_rd)));
          gt_r   <= (34'(e_cur) > 34'($signed(thr_rd)));
          bis_r  <= bis_cur;
          dvd_r  <= {e_mag_cur[31:0], 16'd0};
          drem_r <= '0;
          dcnt_r <= '0;
          if (e_cur == '0) begin
            state_r <= S_UPD;
          end else if (huber_r) begin
            state_r <= S_HMUL;
          end else if (bis_cur) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_HMUL: begin
          if (lt_r || gt_r) begin
            rm_r <= rmul(33'(k_r), oml);
          end else begin
            rm_r <= rmul(e_r, lam);
          end
          state_r <= S_UPD;
        end
        S_DIV: begin
          drem_r <= dq ? 32'(drem2 - {1'b0, k_r}) : drem2[31:0];
          dvd_r  <= {dvd_r[46:0], dq};
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd47) begin
            state_r <= S_Q;
          end
        end
        S_Q: begin
          q_r     <= uu[32:16];
          state_r <= S_D2;
        end
        S_D2: begin
          d2_r    <= ddsq[32:16];
          state_r <= S_F;
        end
        S_F: begin
          f_r     <= LAM_ONE - od[32:16];
          state_r <= S_BMUL;
        end
        S_BMUL: begin
          rm_r    <= rmul(e_r, f_r);
          state_r <= S_UPD;
        end
        S_UPD: begin
          ev_r[v_r]  <= 1'b1;
          tok_r.vld  <= 1'b1;
          tok_r.vidx <= v6_r;
          tok_r.y    <= ny;
          state_r    <= S_WAIT;
        end
        S_WAIT: begin
          wcnt_r <= wcnt_r + 1'b1;
          if (wcnt_r == WW'(WAIT_N)) begin
            if (last_r) begin
              start_r <= 1'b1;
              state_r <= S_T2;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_T2: begin
          if (t2_done) begin
            t2_r    <= t2_w;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!ov_r || out_ready) begin
            ov_r      <= 1'b1;
            o_t2_r    <= t2_r;
            o_warm_r  <= warm_w;
            o_alarm_r <= alarm_w;
            o_nosig_r <= nosig_w;
            o_run_r   <= warm_w ? 16'd0 : ((run_w > 18'd65535) ? 16'hffff : run_w[15:0]);
            if (alarm_w || nosig_w) begin
              fin_r <= 1'b1;
            end
            if (scnt_r != 17'h1ffff) begin
              scnt_r <= scnt_r + 17'd1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = ov_r;
  assign out_t2_value   = o_t2_r;
  assign out_in_warmup  = o_warm_r;
  assign out_alarm      = o_alarm_r;
  assign out_run_length = o_run_r;
  assign out_no_signal  = o_nosig_r;

endmodule
